[hdl/alle_pkg.sv]
// ----------------------------------------------------------------------------
// alle_pkg
// Types and codes shared by the linked list engine: command and result words,
// opcodes, the walk token that travels down the cell row, and a list element.
// ----------------------------------------------------------------------------
`default_nettype none

package alle_pkg;

  localparam int KEY_W   = 32;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_SORT = 3'd3,
    OP_REM_HEAD = 3'd4,
    OP_REM_KEY  = 3'd5,
    OP_SIZE     = 3'd6
  } op_t;

  // What a token does at the cell it visits.
  typedef enum logic [2:0] {
    MD_PASS     = 3'd0,
    MD_SHIFT    = 3'd1,
    MD_PULL     = 3'd2,
    MD_INS_SORT = 3'd3,
    MD_INS_TAIL = 3'd4,
    MD_REM_KEY  = 3'd5,
    MD_CLEAR    = 3'd6
  } mode_t;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } out_word_t;

  typedef struct packed {
    logic                    active;
    mode_t                   mode;
    logic                    hit;
    logic                    carry_v;
    logic signed [KEY_W-1:0] key;
  } tok_t;

  typedef struct packed {
    logic                    v;
    logic signed [KEY_W-1:0] key;
  } elem_t;

endpackage

`default_nettype wire

[hdl/alle_cell.sv]
// ----------------------------------------------------------------------------
// alle_cell
// One list position. Holds one element and acts on the walk token as it
// passes: place a key, shift the row right, pull the row left or clear.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire alle_pkg::tok_t  tok_in,
  output alle_pkg::tok_t       tok_out,
  input  wire alle_pkg::elem_t right_in,
  output alle_pkg::elem_t      el_out
);
  import alle_pkg::*;

  logic                    el_v_r, el_v_nxt;
  logic signed [KEY_W-1:0] el_key_r, el_key_nxt;
  tok_t                    tok_r, tok_nxt;

  always_comb begin
    el_v_nxt   = el_v_r;
    el_key_nxt = el_key_r;
    tok_nxt    = tok_in;
    if (tok_in.active) begin
      case (tok_in.mode)
        MD_INS_SORT: begin
          // place ahead of the first element not less than the new key
          if (!el_v_r || el_key_r >= tok_in.key) begin
            el_v_nxt        = 1'b1;
            el_key_nxt      = tok_in.key;
            tok_nxt.mode    = MD_SHIFT;
            tok_nxt.carry_v = el_v_r;
            tok_nxt.key     = el_key_r;
          end
        end
        MD_INS_TAIL: begin
          if (!el_v_r) begin
            el_v_nxt     = 1'b1;
            el_key_nxt   = tok_in.key;
            tok_nxt.mode = MD_PASS;
          end
        end
        MD_SHIFT: begin
          el_v_nxt        = tok_in.carry_v;
          el_key_nxt      = tok_in.key;
          tok_nxt.carry_v = el_v_r;
          tok_nxt.key     = el_key_r;
        end
        MD_REM_KEY: begin
          if (el_v_r && el_key_r == tok_in.key) begin
            el_v_nxt     = right_in.v;
            el_key_nxt   = right_in.key;
            tok_nxt.mode = MD_PULL;
            tok_nxt.hit  = 1'b1;
          end
        end
        MD_PULL: begin
          el_v_nxt   = right_in.v;
          el_key_nxt = right_in.key;
        end
        MD_CLEAR: begin
          el_v_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      el_v_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      el_v_r <= el_v_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    el_key_r <= el_key_nxt;
  end

  assign tok_out = tok_r;
  assign el_out  = '{v: el_v_r, key: el_key_r};

endmodule

`default_nettype wire

[hdl/alle_ctrl.sv]
// ----------------------------------------------------------------------------
// alle_ctrl
// Command front end: checks full and empty, launches the walk token into the
// cell row, keeps the element count and issues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_ctrl #(
  parameter int SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire alle_pkg::in_word_t in_cmd,
  output logic                    busy,
  output logic                    out_valid,
  output alle_pkg::out_word_t     out_res,
  output alle_pkg::tok_t          tok_launch,
  input  wire alle_pkg::tok_t     tok_done
);
  import alle_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  op_t        op_r, op_nxt;
  tok_t       tok_r, tok_nxt;
  logic       vld_r, vld_nxt;
  out_word_t  res_r, res_nxt;
  logic       accept, full, empty, ok_w;
  op_t        op_in;

  assign accept = start && (state_r == S_IDLE);
  assign full   = (count_r == CNT_W'(SLOTS));
  assign empty  = (count_r == '0);
  assign op_in  = op_t'(in_cmd.opcode);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    tok_nxt   = '0;
    vld_nxt   = 1'b0;
    ok_w      = 1'b0;

    if (accept) begin
      op_nxt      = op_in;
      tok_nxt.key = in_cmd.key;
      case (op_in)
        OP_CLEAR: begin
          tok_nxt.active = 1'b1;
          tok_nxt.mode   = MD_CLEAR;
        end
        OP_INS_HEAD: begin
          tok_nxt.active  = !full;
          tok_nxt.mode    = MD_SHIFT;
          tok_nxt.carry_v = 1'b1;
        end
        OP_INS_TAIL: begin
          tok_nxt.active = !full;
          tok_nxt.mode   = MD_INS_TAIL;
        end
        OP_INS_SORT: begin
          tok_nxt.active = !full;
          tok_nxt.mode   = MD_INS_SORT;
        end
        OP_REM_HEAD: begin
          tok_nxt.active = !empty;
          tok_nxt.mode   = MD_PULL;
          tok_nxt.hit    = 1'b1;
        end
        OP_REM_KEY: begin
          tok_nxt.active = !empty;
          tok_nxt.mode   = MD_REM_KEY;
        end
        OP_SIZE: begin
          ok_w = 1'b1;
        end
        default: begin
          ok_w = 1'b0;
        end
      endcase
      // refused and trivial commands answer at once
      if (tok_nxt.active) begin
        state_nxt = S_WALK;
      end else begin
        vld_nxt = 1'b1;
      end
    end else if (state_r == S_WALK && tok_done.active) begin
      state_nxt = S_IDLE;
      vld_nxt   = 1'b1;
      case (op_r)
        OP_CLEAR: begin
          ok_w      = 1'b1;
          count_nxt = '0;
        end
        OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORT: begin
          ok_w      = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        OP_REM_HEAD, OP_REM_KEY: begin
          ok_w = tok_done.hit;
          if (tok_done.hit) begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          ok_w = 1'b0;
        end
      endcase
    end

    res_nxt.ok       = ok_w;
    res_nxt.count    = COUNT_W'(count_nxt);
    res_nxt.is_empty = (count_nxt == '0);
    res_nxt.is_full  = (count_nxt == CNT_W'(SLOTS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      op_r    <= OP_SIZE;
      tok_r   <= '0;
      vld_r   <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      op_r    <= op_nxt;
      tok_r   <= tok_nxt;
      vld_r   <= vld_nxt;
      res_r   <= res_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = vld_r;
  assign out_res    = res_r;
  assign tok_launch = tok_r;

`ifndef SYNTH
  a_vld_idle: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> state_r == S_IDLE)
    else $error("result strobe raised during a walk");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("element count beyond pool size");

  a_done_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_done.active |-> state_r == S_WALK)
    else $error("token left the row with no walk in progress");

  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || vld_r))
    else $error("accepted command neither walks nor answers");
`endif

endmodule

`default_nettype wire

[hdl/array_linked_list_engine.sv]
// Clear, inserts and removals pass through the controller's token register,
// then one token register per cell down the row, then the result register
// that raises the result strobe; size, unused opcodes and refused commands
// raise the strobe in the next cycle. No new command is taken while a walk is
// in progress. Results cannot be stalled. Synchronous reset empties the list.
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Keyed list held in a row of cells in list order, with a front-end
// controller that launches a walk token for each command.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_engine #(
  parameter int SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire alle_pkg::in_word_t in_cmd,
  output logic                    busy,
  output logic                    out_valid,
  output alle_pkg::out_word_t     out_res
);
  import alle_pkg::*;

  tok_t  tok_chain [SLOTS+1];
  elem_t el_row    [SLOTS+1];

  // beyond the last cell reads as empty
  assign el_row[SLOTS] = '0;

  alle_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .tok_launch (tok_chain[0]),
    .tok_done   (tok_chain[SLOTS])
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    alle_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .right_in (el_row[i+1]),
      .el_out   (el_row[i])
    );
  end

endmodule

`default_nettype wire
